@@ hw/rtl/ttlpr_pkg.sv @@
// ----------------------------------------------------------------------------
// Touch tap and long-press recognizer package
// Shared constants, codes and types for the recognizer modules.
// ----------------------------------------------------------------------------
package ttlpr_pkg;

    // Size of the active touch table.
    localparam int TOUCH_SLOTS = 8;
    localparam int SLOT_IDX_W  = (TOUCH_SLOTS > 1) ? $clog2(TOUCH_SLOTS) : 1;

    // Field widths.
    localparam int ID_W     = 32;
    localparam int POS_W    = 12;
    localparam int TIME_W   = 32;
    localparam int ENTITY_W = 16;
    localparam int KIND_W   = 2;
    localparam int GEST_W   = 2;
    localparam int SQ_W     = 2 * POS_W;

    // Stream and configuration port widths.
    localparam int S_DATA_W   = 112;
    localparam int M_DATA_W   = 48;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;

    // Input tdata bit positions.
    localparam int S_ID_LSB  = 0;
    localparam int S_X_LSB   = S_ID_LSB + ID_W;
    localparam int S_Y_LSB   = S_X_LSB + POS_W;
    localparam int S_NOW_LSB = S_Y_LSB + POS_W;
    localparam int S_HV_BIT  = S_NOW_LSB + TIME_W;
    localparam int S_HE_LSB  = S_HV_BIT + 1;

    // Event kinds.
    localparam logic [KIND_W-1:0] KIND_DOWN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HOLD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UP   = 2'd2;

    // Gesture codes.
    localparam logic [GEST_W-1:0] GEST_NONE = 2'd0;
    localparam logic [GEST_W-1:0] GEST_TAP  = 2'd1;
    localparam logic [GEST_W-1:0] GEST_LONG = 2'd2;
    localparam logic [GEST_W-1:0] GEST_DROP = 2'd3;

    // Configuration register indexes and reset values.
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_PRESS = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TAP_DIST   = 1'd1;
    localparam logic [TIME_W-1:0]     LONG_PRESS_RST = 32'd500;
    localparam logic [POS_W-1:0]      TAP_DIST_RST   = 12'd20;

    typedef logic [SLOT_IDX_W-1:0] slot_idx_t;

    // Step commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic lookup;
        logic square;
        logic commit;
    } ttlpr_cmd_t;

endpackage

@@ hw/rtl/ttlpr_dp.sv @@
// ----------------------------------------------------------------------------
// Touch tap and long-press recognizer datapath
// Holds the touch table, configuration registers and the per-event
// arithmetic: slot match, distance and elapsed-time checks, result register.
// ----------------------------------------------------------------------------
module ttlpr_dp
    import ttlpr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ttlpr_cmd_t            cmd,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic [KIND_W-1:0]     s_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic [GEST_W-1:0]     m_tuser
);

    // Configuration registers.
    logic [TIME_W-1:0] long_press_reg;
    logic [POS_W-1:0]  tap_dist_reg;

    // Captured input transaction.
    logic [KIND_W-1:0]   in_kind_reg;
    logic [ID_W-1:0]     in_id_reg;
    logic [POS_W-1:0]    in_x_reg;
    logic [POS_W-1:0]    in_y_reg;
    logic [TIME_W-1:0]   in_now_reg;
    logic                in_hv_reg;
    logic [ENTITY_W-1:0] in_he_reg;

    // Touch table.
    logic [TOUCH_SLOTS-1:0] slot_valid_reg;
    logic [ID_W-1:0]        slot_id_reg     [TOUCH_SLOTS];
    logic [TIME_W-1:0]      slot_start_reg  [TOUCH_SLOTS];
    logic                   slot_tv_reg     [TOUCH_SLOTS];
    logic [ENTITY_W-1:0]    slot_target_reg [TOUCH_SLOTS];
    logic [POS_W-1:0]       slot_x_reg      [TOUCH_SLOTS];
    logic [POS_W-1:0]       slot_y_reg      [TOUCH_SLOTS];

    // Lookup stage results.
    logic                hit_reg;
    slot_idx_t           hit_idx_reg;
    logic                free_ok_reg;
    slot_idx_t           free_idx_reg;
    logic [POS_W-1:0]    dx_reg;
    logic [POS_W-1:0]    dy_reg;
    logic                late_reg;
    logic                same_tgt_reg;
    logic                tv_reg;
    logic [ENTITY_W-1:0] tgt_reg;

    // Square stage results.
    logic [SQ_W-1:0] dx2_reg;
    logic [SQ_W-1:0] dy2_reg;
    logic [SQ_W-1:0] t2_reg;

    // Result register.
    logic [GEST_W-1:0]   out_gest_reg;
    logic [ENTITY_W-1:0] out_tgt_reg;
    logic [ID_W-1:0]     out_id_reg;

    // Combinational lookup signals.
    logic        hit;
    slot_idx_t   hit_idx;
    logic        free_ok;
    slot_idx_t   free_idx;
    logic [POS_W-1:0]  sx;
    logic [POS_W-1:0]  sy;
    logic [TIME_W-1:0] dur;

    // Commit stage signals.
    logic [SQ_W:0]       d2;
    logic                near;
    logic                do_insert;
    logic                do_free;
    logic [GEST_W-1:0]   gest;
    logic [ENTITY_W-1:0] gest_tgt;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg <= LONG_PRESS_RST;
            tap_dist_reg   <= TAP_DIST_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_LONG_PRESS: long_press_reg <= cfg_wdata[TIME_W-1:0];
                REG_TAP_DIST:   tap_dist_reg   <= cfg_wdata[POS_W-1:0];
                default:        ;
            endcase
        end
    end

    // Capture the accepted transaction.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_kind_reg <= s_tuser;
            in_id_reg   <= s_tdata[S_ID_LSB +: ID_W];
            in_x_reg    <= s_tdata[S_X_LSB +: POS_W];
            in_y_reg    <= s_tdata[S_Y_LSB +: POS_W];
            in_now_reg  <= s_tdata[S_NOW_LSB +: TIME_W];
            in_hv_reg   <= s_tdata[S_HV_BIT];
            in_he_reg   <= s_tdata[S_HE_LSB +: ENTITY_W];
        end
    end

    // Parallel id match and lowest free slot search.
    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = TOUCH_SLOTS - 1; i >= 0; i--)
        begin
            if (slot_valid_reg[i] && (slot_id_reg[i] == in_id_reg))
            begin
                hit     = 1'b1;
                hit_idx = SLOT_IDX_W'(i);
            end
            if (!slot_valid_reg[i])
            begin
                free_ok  = 1'b1;
                free_idx = SLOT_IDX_W'(i);
            end
        end
    end

    // Read the matched slot and form the differences.
    assign sx  = slot_x_reg[hit_idx];
    assign sy  = slot_y_reg[hit_idx];
    assign dur = in_now_reg - slot_start_reg[hit_idx];

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            hit_reg      <= hit;
            hit_idx_reg  <= hit_idx;
            free_ok_reg  <= free_ok;
            free_idx_reg <= free_idx;
            dx_reg       <= (in_x_reg > sx) ? (in_x_reg - sx) : (sx - in_x_reg);
            dy_reg       <= (in_y_reg > sy) ? (in_y_reg - sy) : (sy - in_y_reg);
            late_reg     <= (dur >= long_press_reg);
            tv_reg       <= slot_tv_reg[hit_idx];
            tgt_reg      <= slot_target_reg[hit_idx];
            same_tgt_reg <= in_hv_reg && slot_tv_reg[hit_idx]
                            && (in_he_reg == slot_target_reg[hit_idx]);
        end
    end

    // Squares of the offsets and of the tap radius.
    always_ff @(posedge clk)
    begin
        if (cmd.square)
        begin
            dx2_reg <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
            dy2_reg <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
            t2_reg  <= SQ_W'(tap_dist_reg) * SQ_W'(tap_dist_reg);
        end
    end

    // Decide the gesture and the table update.
    assign d2   = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    assign near = (d2 < {1'b0, t2_reg});

    always_comb
    begin
        gest      = GEST_NONE;
        gest_tgt  = '0;
        do_insert = 1'b0;
        do_free   = 1'b0;
        case (in_kind_reg)
            KIND_DOWN:
            begin
                if (!hit_reg)
                begin
                    if (free_ok_reg)
                        do_insert = 1'b1;
                    else
                        gest = GEST_DROP;
                end
            end
            KIND_HOLD:
            begin
                if (hit_reg && late_reg)
                begin
                    do_free = 1'b1;
                    if (same_tgt_reg)
                    begin
                        gest     = GEST_LONG;
                        gest_tgt = tgt_reg;
                    end
                end
            end
            KIND_UP:
            begin
                if (hit_reg)
                begin
                    do_free = 1'b1;
                    if (tv_reg && near && !late_reg)
                    begin
                        gest     = GEST_TAP;
                        gest_tgt = tgt_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    // Slot valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_valid_reg <= '0;
        else if (cmd.commit)
        begin
            if (do_insert)
                slot_valid_reg[free_idx_reg] <= 1'b1;
            else if (do_free)
                slot_valid_reg[hit_idx_reg] <= 1'b0;
        end
    end

    // Slot payload, written when a new touch is opened.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && do_insert)
        begin
            slot_id_reg[free_idx_reg]     <= in_id_reg;
            slot_start_reg[free_idx_reg]  <= in_now_reg;
            slot_tv_reg[free_idx_reg]     <= in_hv_reg;
            slot_target_reg[free_idx_reg] <= in_he_reg;
            slot_x_reg[free_idx_reg]      <= in_x_reg;
            slot_y_reg[free_idx_reg]      <= in_y_reg;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_gest_reg <= gest;
            out_tgt_reg  <= gest_tgt;
            out_id_reg   <= in_id_reg;
        end
    end

    assign m_tdata = {out_id_reg, out_tgt_reg};
    assign m_tuser = out_gest_reg;

endmodule

@@ hw/rtl/ttlpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// Touch tap and long-press recognizer controller
// Sequences each event through lookup, square and commit steps and owns the
// stream handshake flags.
// ----------------------------------------------------------------------------
module ttlpr_ctrl
    import ttlpr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output ttlpr_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SQUARE,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_tready_reg;
    logic   s_tready_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    // The result register can be reloaded when empty or being emptied.
    assign out_free = !m_tvalid_reg || m_tready;

    // Next state and handshake flags.
    always_comb
    begin
        state_next    = state_reg;
        s_tready_next = s_tready_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready_reg)
                begin
                    state_next    = ST_LOOKUP;
                    s_tready_next = 1'b0;
                end
            end
            ST_LOOKUP:
                state_next = ST_SQUARE;
            ST_SQUARE:
                state_next = ST_COMMIT;
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    state_next    = ST_IDLE;
                    s_tready_next = 1'b1;
                    m_tvalid_next = 1'b1;
                end
            end
            default:
            begin
                state_next    = ST_IDLE;
                s_tready_next = 1'b1;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s_tready_reg <= s_tready_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Datapath step commands.
    assign cmd.load   = s_tvalid && s_tready_reg;
    assign cmd.lookup = (state_reg == ST_LOOKUP);
    assign cmd.square = (state_reg == ST_SQUARE);
    assign cmd.commit = (state_reg == ST_COMMIT) && out_free;

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

@@ hw/rtl/touch_tap_long_press_recognizer_unit.sv @@
// ----------------------------------------------------------------------------
// Touch tap and long-press recognizer
// Turns down, hold and up touch events into tap and long-press gestures.
// ----------------------------------------------------------------------------
// Usage:
// Events arrive on the slave stream: s_tuser carries the event kind and
// s_tdata the touch id, position, time and hit-tested target. Each accepted
// transaction yields exactly one result transaction on the master stream:
// m_tuser carries the gesture code, m_tdata the target and the touch id.
// The two registers (long-press time, tap radius) are written through the
// cfg_wdata port; the user must write them only while no event is in flight (not enforced).
// An event goes through capture, slot lookup, the squared-distance
// multiplies and the commit that updates the table and loads the result
// register. The result is on offer once the commit has loaded it, and a new
// event is taken only after that commit, never while one is in flight.
// s_tready is low while an event is being worked on.
// If the receiver stalls, the result stays in the output register; the next
// event may still be accepted and worked on, and its commit waits until the
// previous result has been taken.
// Reset empties the touch table and restores long-press time 500 ticks and
// tap radius 20 pixels; no clearing pass is needed.
// ----------------------------------------------------------------------------
module touch_tap_long_press_recognizer_unit
    import ttlpr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // touch_id[31:0], touch_x[43:32], touch_y[55:44], now_time[87:56],
    // hit_valid[88], hit_entity[104:89], zero padding above
    input  logic [S_DATA_W-1:0]   s_tdata,
    // kind[1:0]
    input  logic [KIND_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // target_entity[15:0], gesture_touch_id[47:16]
    output logic [M_DATA_W-1:0]   m_tdata,
    // gesture[1:0]
    output logic [GEST_W-1:0]     m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    ttlpr_cmd_t cmd;

    // Sequencer.
    ttlpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Table and arithmetic.
    ttlpr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef ASSERT_OFF
    // An accepted event keeps the input closed while it is worked on.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready ##1 !s_tready)
        else $error("input reopened while an event was in flight");

    // After acceptance, once the lookup, square and commit states have passed, a result is on offer.
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> ##3 m_tvalid)
        else $error("no result three cycles after an accepted event");

    // Results without a gesture target carry a zero target.
    a_zero_target: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == GEST_NONE || m_tuser == GEST_DROP))
        |-> (m_tdata[ENTITY_W-1:0] == '0))
        else $error("non-zero target on a result without a gesture");
`endif

endmodule
